// ===== sv/script_lexer_assert.svh =====
// Assertion macros for the script lexer.
// Used by the top level; no other dependencies.
`ifndef SCRIPT_LEXER_ASSERT_SVH
`define SCRIPT_LEXER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SL_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SL_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== sv/slex_pkg.sv =====
// Package for the script lexer: token codes, modes, result record type.
// No dependencies.
`timescale 1ns / 1ps
package slex_pkg;
   localparam int KEYWORD_MAX_LEN_DEF = 8;
   localparam int POSITION_BITS_DEF   = 24;
   localparam int MAX_RESULTS         = 3;

   localparam logic [5:0] TK_DOT    = 6'd9;
   localparam logic [5:0] TK_SLASH  = 6'd12;
   localparam logic [5:0] TK_BANG   = 6'd15;
   localparam logic [5:0] TK_EQUAL  = 6'd17;
   localparam logic [5:0] TK_GREATER = 6'd19;
   localparam logic [5:0] TK_LESS   = 6'd21;
   localparam logic [5:0] TK_IDENT  = 6'd23;
   localparam logic [5:0] TK_STRING = 6'd24;
   localparam logic [5:0] TK_NUMBER = 6'd25;
   localparam logic [5:0] TK_KW0    = 6'd26;
   localparam logic [5:0] TK_ERROR  = 6'd47;
   localparam logic [5:0] TK_END    = 6'd48;

   localparam logic [2:0] FC_NONE    = 3'd0;
   localparam logic [2:0] FC_COMMENT = 3'd1;
   localparam logic [2:0] FC_STRING  = 3'd2;
   localparam logic [2:0] FC_ESCAPE  = 3'd3;
   localparam logic [2:0] FC_CHAR    = 3'd4;

   localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

   typedef enum logic [11:0] {
      M_IDLE     = 12'b0000_0000_0001,
      M_IDENT    = 12'b0000_0000_0010,
      M_NUM_INT  = 12'b0000_0000_0100,
      M_NUM_DOT  = 12'b0000_0000_1000,
      M_NUM_FRAC = 12'b0000_0001_0000,
      M_OP       = 12'b0000_0010_0000,
      M_SLASH    = 12'b0000_0100_0000,
      M_LINE_CMT = 12'b0000_1000_0000,
      M_BLK_BODY = 12'b0001_0000_0000,
      M_BLK_STAR = 12'b0010_0000_0000,
      M_STR_BODY = 12'b0100_0000_0000,
      M_STR_ESC  = 12'b1000_0000_0000
   } mode_type;

   typedef struct packed {
      logic        item_kind;
      logic [5:0]  token_kind;
      logic [2:0]  fault_code;
      logic [23:0] token_offset;
      logic [15:0] token_length;
      logic [23:0] line_number;
      logic [7:0]  content_byte;
      logic        last_of_run;
   } result_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Code of a single-character punctuation byte; 6'h3F when not one.
   function automatic logic [5:0] single_code(input logic [7:0] c);
      case (c)
         "(": return 6'd0;
         ")": return 6'd1;
         "{": return 6'd2;
         "}": return 6'd3;
         "[": return 6'd4;
         "]": return 6'd5;
         ":": return 6'd6;
         ";": return 6'd7;
         ",": return 6'd8;
         ".": return 6'd9;
         "-": return 6'd10;
         "+": return 6'd11;
         "/": return 6'd12;
         "%": return 6'd13;
         "*": return 6'd14;
         default: return 6'h3F;
      endcase
   endfunction

   function automatic logic [5:0] op_base(input logic [7:0] op);
      case (op)
         "!": return TK_BANG;
         "=": return TK_EQUAL;
         ">": return TK_GREATER;
         default: return TK_LESS;
      endcase
   endfunction
endpackage

// ===== sv/slex_stream_if.sv =====
// Valid/ready channel interface carrying one payload.
// No dependencies.
`timescale 1ns / 1ps
interface slex_stream_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/slex_keyword.sv =====
// Parallel keyword matcher over the identifier buffer.
// Depends on slex_pkg.
`timescale 1ns / 1ps
module slex_keyword #(
   parameter int KEYWORD_MAX_LEN = slex_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  logic [KEYWORD_MAX_LEN-1:0][7:0]     word,
   input  logic [$clog2(KEYWORD_MAX_LEN+2)-1:0] word_len,
   output logic [5:0]                          kind
);
   import slex_pkg::*;
   localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);

   // Compare the buffer against one keyword of up to eight bytes.
   function automatic logic hit(input logic [KEYWORD_MAX_LEN-1:0][7:0] w,
                                input logic [LW-1:0] n,
                                input logic [63:0] txt, input int len);
      logic ok;
      ok = (n == LW'(len));
      for (int i = 0; i < 8; i++) begin
         if (i < len && i < KEYWORD_MAX_LEN)
            if (w[i] != txt[63-8*i -: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   always_comb begin
      kind = TK_IDENT;
      if      (hit(word, word_len, {"and", 40'd0}, 3))      kind = TK_KW0 + 6'd0;
      else if (hit(word, word_len, {"break", 24'd0}, 5))    kind = TK_KW0 + 6'd1;
      else if (hit(word, word_len, {"catch", 24'd0}, 5))    kind = TK_KW0 + 6'd2;
      else if (hit(word, word_len, {"class", 24'd0}, 5))    kind = TK_KW0 + 6'd3;
      else if (hit(word, word_len, {"co", "ntinue"}, 8))    kind = TK_KW0 + 6'd4;
      else if (hit(word, word_len, {"else", 32'd0}, 4))     kind = TK_KW0 + 6'd5;
      else if (hit(word, word_len, {"false", 24'd0}, 5))    kind = TK_KW0 + 6'd6;
      else if (hit(word, word_len, {"for", 40'd0}, 3))      kind = TK_KW0 + 6'd7;
      else if (hit(word, word_len, {"fun", 40'd0}, 3))      kind = TK_KW0 + 6'd8;
      else if (hit(word, word_len, {"if", 48'd0}, 2))       kind = TK_KW0 + 6'd9;
      else if (hit(word, word_len, {"nil", 40'd0}, 3))      kind = TK_KW0 + 6'd10;
      else if (hit(word, word_len, {"or", 48'd0}, 2))       kind = TK_KW0 + 6'd11;
      else if (hit(word, word_len, {"print", 24'd0}, 5))    kind = TK_KW0 + 6'd12;
      else if (hit(word, word_len, {"r", "eturn", 16'd0}, 6)) kind = TK_KW0 + 6'd13;
      else if (hit(word, word_len, {"super", 24'd0}, 5))    kind = TK_KW0 + 6'd14;
      else if (hit(word, word_len, {"this", 32'd0}, 4))     kind = TK_KW0 + 6'd15;
      else if (hit(word, word_len, {"throw", 24'd0}, 5))    kind = TK_KW0 + 6'd16;
      else if (hit(word, word_len, {"true", 32'd0}, 4))     kind = TK_KW0 + 6'd17;
      else if (hit(word, word_len, {"try", 40'd0}, 3))      kind = TK_KW0 + 6'd18;
      else if (hit(word, word_len, {"var", 40'd0}, 3))      kind = TK_KW0 + 6'd19;
      else if (hit(word, word_len, {"w", "hile", 24'd0}, 5)) kind = TK_KW0 + 6'd20;
   end
endmodule

// ===== sv/slex_out_queue.sv =====
// Output queue: holds the up to three results of one byte and hands them
// out one per cycle while rsp.ready holds. Depends on slex_pkg, slex_stream_if.
`timescale 1ns / 1ps
module slex_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [1:0]            push_count,
   input  slex_pkg::result_type  push_data [3],
   output logic                  has_room,
   slex_stream_if.source         rsp
);
   import slex_pkg::*;

   // Four-entry circular buffer; room means three free slots.
   result_type  buf_ff [4];
   logic [1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop;

   assign pop         = rsp.valid && rsp.ready;
   assign rsp.valid   = cnt_ff != 3'd0;
   assign rsp.payload = buf_ff[rd_ff];
   assign has_room    = (cnt_ff - 3'(pop)) <= 3'd1;

   always_comb begin
      rd_in  = rd_ff + 2'(pop);
      wr_in  = wr_ff + (push ? push_count : 2'd0);
      cnt_in = cnt_ff - 3'(pop) + (push ? {1'b0, push_count} : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload writes need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < 3; i++)
            if (2'(i) < push_count) buf_ff[wr_ff + 2'(i)] <= push_data[i];
      end
   end
endmodule

// ===== sv/script_lexer.sv =====
// Script lexer: a byte transfer is scanned in the cycle it is accepted, and its
// results are registered in the output queue; results leave one per cycle while
// the receiver is ready. A byte is accepted every cycle while at most one result
// stays queued after the current result transfer, so bytes with two or three
// results are paced by the output side. Synchronous active-high reset returns to
// idle at position 0, line 1; end of text does the same after its end token.
`timescale 1ns / 1ps
`include "script_lexer_assert.svh"
module script_lexer #(
   parameter int KEYWORD_MAX_LEN = slex_pkg::KEYWORD_MAX_LEN_DEF,
   parameter int POSITION_BITS   = slex_pkg::POSITION_BITS_DEF
) (
   input logic           clock,
   input logic           reset,
   slex_stream_if.sink   req,
   slex_stream_if.source rsp
);
   import slex_pkg::*;
   localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int IW = $clog2(KEYWORD_MAX_LEN);

   mode_type                          mode_ff, mode_in;
   logic [POSITION_BITS-1:0]          pos_ff, pos_in, begin_ff, begin_in;
   logic [23:0]                       line_ff, line_in;
   logic [7:0]                        held_ff, held_in;
   logic [KEYWORD_MAX_LEN-1:0][7:0]   word_ff, word_in;
   logic [LW-1:0]                     wlen_ff, wlen_in;
   logic [15:0]                       cnt_ff, cnt_in;
   logic                              single_ff, single_in;

   logic        accept, room;
   logic [7:0]  b;
   logic [5:0]  kw_kind;
   result_type  res [3];
   logic [1:0]  nres;

   assign b         = req.payload;
   assign req.ready = room;
   assign accept    = req.valid && room;

   slex_keyword #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
      .word(word_ff), .word_len(wlen_ff), .kind(kw_kind));

   slex_out_queue u_queue (
      .clock(clock), .reset(reset), .push(accept), .push_count(nres),
      .push_data(res), .has_room(room), .rsp(rsp));

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] d);
      logic [16:0] s;
      s = {1'b0, a} + 17'(d);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // Next-state and result logic for one byte.
   always_comb begin
      logic       restart, idle_scan, line_bump;
      logic [23:0] line_tok;
      logic [5:0]  sc;
      logic [7:0]  delim, esc;
      mode_in   = mode_ff;
      begin_in  = begin_ff;
      held_in   = held_ff;
      word_in   = word_ff;
      wlen_in   = wlen_ff;
      cnt_in    = cnt_ff;
      single_in = single_ff;
      restart   = 1'b0;
      idle_scan = 1'b0;
      line_bump = 1'b0;
      nres      = 2'd0;
      for (int i = 0; i < 3; i++) res[i] = '0;
      line_tok  = line_ff;
      delim     = single_ff ? 8'h27 : 8'h22;
      esc       = (b == "n") ? 8'h0A : (b == "r") ? 8'h0D : (b == "t") ? 8'h09 : b;
      sc        = single_code(b);

      case (mode_ff)
         M_IDENT: begin
            if (is_alpha(b) || is_digit(b)) begin
               if (wlen_ff < LW'(KEYWORD_MAX_LEN)) word_in[wlen_ff[IW-1:0]] = b;
               if (wlen_ff <= LW'(KEYWORD_MAX_LEN)) wlen_in = wlen_ff + 1'b1;
               cnt_in = sat_add(cnt_ff, 2'd1);
            end else begin
               res[0].token_kind   = kw_kind;
               res[0].token_offset = 24'(begin_ff);
               res[0].token_length = cnt_ff;
               nres = 2'd1;
               idle_scan = 1'b1;
            end
         end
         M_NUM_INT, M_NUM_FRAC: begin
            if (is_digit(b)) cnt_in = sat_add(cnt_ff, 2'd1);
            else if (b == "." && mode_ff == M_NUM_INT) mode_in = M_NUM_DOT;
            else begin
               res[0].token_kind   = TK_NUMBER;
               res[0].token_offset = 24'(begin_ff);
               res[0].token_length = cnt_ff;
               nres = 2'd1;
               idle_scan = 1'b1;
            end
         end
         M_NUM_DOT: begin
            if (is_digit(b)) begin
               cnt_in  = sat_add(cnt_ff, 2'd2);
               mode_in = M_NUM_FRAC;
            end else begin
               res[0].token_kind   = TK_NUMBER;
               res[0].token_offset = 24'(begin_ff);
               res[0].token_length = cnt_ff;
               res[1].token_kind   = TK_DOT;
               res[1].token_offset = 24'(pos_ff - 1'b1);
               res[1].token_length = 16'd1;
               nres = 2'd2;
               idle_scan = 1'b1;
            end
         end
         M_OP: begin
            res[0].token_offset = 24'(begin_ff);
            nres = 2'd1;
            if (b == "=") begin
               res[0].token_kind   = op_base(held_ff) + 6'd1;
               res[0].token_length = 16'd2;
               mode_in = M_IDLE;
            end else begin
               res[0].token_kind   = op_base(held_ff);
               res[0].token_length = 16'd1;
               idle_scan = 1'b1;
            end
         end
         M_SLASH: begin
            if (b == "/") mode_in = M_LINE_CMT;
            else if (b == "*") mode_in = M_BLK_BODY;
            else begin
               res[0].token_kind   = TK_SLASH;
               res[0].token_offset = 24'(begin_ff);
               res[0].token_length = 16'd1;
               nres = 2'd1;
               idle_scan = 1'b1;
            end
         end
         M_LINE_CMT: begin
            if (b == 8'h0A) begin
               line_bump = 1'b1;
               mode_in = M_IDLE;
            end else if (b == 8'h00) idle_scan = 1'b1;
         end
         M_BLK_BODY, M_BLK_STAR: begin
            if (b == 8'h00) begin
               res[0].token_kind   = TK_ERROR;
               res[0].fault_code   = FC_COMMENT;
               res[0].token_offset = 24'(begin_ff);
               res[1].token_kind   = TK_END;
               res[1].token_offset = 24'(pos_ff);
               nres = 2'd2;
               restart = 1'b1;
            end else if (b == "*") mode_in = M_BLK_STAR;
            else if (b == "/" && mode_ff == M_BLK_STAR) mode_in = M_IDLE;
            else begin
               line_bump = (b == 8'h0A);
               mode_in = M_BLK_BODY;
            end
         end
         M_STR_BODY: begin
            res[0].token_offset = 24'(begin_ff);
            res[0].token_kind   = TK_STRING;
            if (b == delim) begin
               cnt_in = sat_add(cnt_ff, 2'd1);
               res[0].token_length = cnt_in;
               nres = 2'd1;
               mode_in = M_IDLE;
            end else if (b == 8'h5C) mode_in = M_STR_ESC;
            else if (b == 8'h00) begin
               res[0].token_kind   = TK_ERROR;
               res[0].fault_code   = FC_STRING;
               res[1].token_kind   = TK_END;
               res[1].token_offset = 24'(pos_ff);
               nres = 2'd2;
               restart = 1'b1;
            end else begin
               cnt_in = sat_add(cnt_ff, 2'd1);
               res[0].item_kind    = 1'b1;
               res[0].content_byte = b;
               nres = 2'd1;
            end
         end
         M_STR_ESC: begin
            res[0].token_offset = 24'(begin_ff);
            nres = 2'd1;
            if (b == 8'h00) begin
               res[0].token_kind   = TK_ERROR;
               res[0].fault_code   = FC_STRING;
               res[1].token_kind   = TK_END;
               res[1].token_offset = 24'(pos_ff);
               nres = 2'd2;
               restart = 1'b1;
            end else if (b == 8'h27 || b == 8'h5C || b == 8'h22 || b == "n" ||
                         b == "r" || b == "t") begin
               cnt_in = sat_add(cnt_ff, 2'd1);
               res[0].item_kind    = 1'b1;
               res[0].token_kind   = TK_STRING;
               res[0].content_byte = esc;
               mode_in = M_STR_BODY;
            end else begin
               res[0].token_kind = TK_ERROR;
               res[0].fault_code = FC_ESCAPE;
               mode_in = M_IDLE;
            end
         end
         default: idle_scan = 1'b1;
      endcase

      // Scanning a byte from the idle state appends at most one result.
      if (idle_scan) begin
         mode_in = M_IDLE;
         if (b == 8'h00) begin
            res[nres].token_kind   = TK_END;
            res[nres].token_offset = 24'(pos_ff);
            nres = nres + 2'd1;
            restart = 1'b1;
         end else if (b == " " || b == 8'h0D || b == 8'h09) begin
         end else if (b == 8'h0A) line_bump = 1'b1;
         else if (is_alpha(b)) begin
            mode_in = M_IDENT; begin_in = pos_ff; cnt_in = 16'd1;
            word_in[0] = b; wlen_in = LW'(1);
         end else if (is_digit(b)) begin
            mode_in = M_NUM_INT; begin_in = pos_ff; cnt_in = 16'd1;
         end else if (b == "!" || b == "=" || b == "<" || b == ">") begin
            mode_in = M_OP; held_in = b; begin_in = pos_ff;
         end else if (b == "/") begin
            mode_in = M_SLASH; begin_in = pos_ff;
         end else if (b == 8'h22 || b == 8'h27) begin
            mode_in = M_STR_BODY; single_in = (b == 8'h27);
            begin_in = pos_ff; cnt_in = 16'd1;
         end else if (sc != 6'h3F) begin
            res[nres].token_kind   = sc;
            res[nres].token_offset = 24'(pos_ff);
            res[nres].token_length = 16'd1;
            nres = nres + 2'd1;
         end else begin
            res[nres].token_kind   = TK_ERROR;
            res[nres].fault_code   = FC_CHAR;
            res[nres].token_offset = 24'(pos_ff);
            nres = nres + 2'd1;
         end
      end

      for (int i = 0; i < 3; i++) begin
         res[i].line_number = line_tok;
         res[i].last_of_run = (2'(i) == nres - 2'd1);
      end

      line_in = (line_bump && line_ff != LINE_MAX) ? line_ff + 24'd1 : line_ff;
      pos_in  = pos_ff + 1'b1;
      if (restart) begin
         mode_in = M_IDLE; pos_in = '0; begin_in = '0; line_in = 24'd1;
         held_in = '0; wlen_in = '0; cnt_in = '0; single_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; pos_ff <= '0; begin_ff <= '0; line_ff <= 24'd1;
         held_ff <= '0; wlen_ff <= '0; cnt_ff <= '0; single_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in; pos_ff <= pos_in; begin_ff <= begin_in;
         line_ff <= line_in; held_ff <= held_in; wlen_ff <= wlen_in;
         cnt_ff <= cnt_in; single_ff <= single_in;
      end
   end

   // Identifier bytes need no reset.
   always_ff @(posedge clock) begin
      if (accept) word_ff <= word_in;
   end

   `SL_ASSERT_IMPL(a_onehot_mode, clock, reset, $onehot(mode_ff), "mode not one-hot")
   `SL_ASSERT_IMPL(a_line_nonzero, clock, reset, line_ff != 24'd0, "line count is zero")
   `SL_ASSERT_IMPL(a_end_restart, clock, reset,
      (accept && mode_ff == M_IDLE && b == 8'h00) |=> (pos_ff == '0),
      "end of text did not restart position")
   `SL_ASSERT_IMPL(a_rsp_hold, clock, reset,
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)),
      "stalled result changed or dropped")
endmodule

// ===== tb/script_lexer_test.sv =====
// Self-checking testbench for the script lexer: drives source text bytes and
// checks each token and string content record against a built-in predictor.
// Depends on slex_pkg, slex_stream_if and script_lexer.
`timescale 1ns / 1ps
module script_lexer_test;
   import slex_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum logic [3:0] {
      S_IDLE, S_IDENT, S_NUM_INT, S_NUM_DOT, S_NUM_FRAC, S_OP, S_SLASH,
      S_LINE_CMT, S_BLK_BODY, S_BLK_STAR, S_STR_BODY, S_STR_ESC
   } scan_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slex_stream_if #(.payload_type(logic [7:0])) req ();
   slex_stream_if #(.payload_type(result_type)) rsp ();

   script_lexer dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // Predictor state.
   scan_state_type scan_state;
   logic [23:0]    scan_pos;
   logic [23:0]    scan_begin;
   logic [23:0]    scan_line;
   logic [7:0]     scan_held;
   logic [7:0]     scan_word [8];
   int unsigned    scan_word_len;
   int unsigned    scan_count;
   logic           scan_single;
   logic           scan_restart;

   result_type expected_tokens [$];
   result_type run_tokens [$];

   int   error_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_off = 1'b0;
   int   quiet_cycles = 0;

   // Free-running clock, 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // Keyword table as an array of words, index order gives the code.
   string keywords [21] = '{"and", "break", "catch", "class", "continue", "else",
      "false", "for", "fun", "if", "nil", "or", "print", "return", "super",
      "this", "throw", "true", "try", "var", "while"};

   function automatic bit alpha_byte(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic bit digit_byte(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [5:0] word_token();
      string w;
      bit    hit;
      for (int i = 0; i < 21; i++) begin
         w = keywords[i];
         hit = (scan_word_len == w.len());
         for (int j = 0; j < w.len() && hit; j++) begin
            if (scan_word[j] != w[j]) hit = 0;
         end
         if (hit) return TK_KW0 + 6'(i);
      end
      return TK_IDENT;
   endfunction

   function automatic void add_count(input int unsigned by);
      scan_count = scan_count + by;
      if (scan_count > 16'hFFFF) scan_count = 16'hFFFF;
   endfunction

   function automatic void next_line();
      if (scan_line != LINE_MAX) scan_line = scan_line + 24'd1;
   endfunction

   function automatic void push_token(input logic ik, input logic [5:0] tk,
         input logic [2:0] fc, input logic [23:0] off, input int unsigned len,
         input logic [7:0] cb);
      result_type r;
      r.item_kind = ik;
      r.token_kind = tk;
      r.fault_code = fc;
      r.token_offset = off;
      r.token_length = 16'(len);
      r.line_number = scan_line;
      r.content_byte = cb;
      r.last_of_run = 1'b0;
      run_tokens.push_back(r);
   endfunction

   function automatic void clear_scanner();
      scan_state = S_IDLE;
      scan_pos = '0;
      scan_begin = '0;
      scan_line = 24'd1;
      scan_held = '0;
      foreach (scan_word[i]) scan_word[i] = '0;
      scan_word_len = 0;
      scan_count = 0;
      scan_single = 1'b0;
   endfunction

   function automatic void finish_text(input logic [23:0] pos);
      push_token(1'b0, TK_END, FC_NONE, pos, 0, 8'h00);
      scan_restart = 1'b1;
   endfunction

   function automatic void scan_fresh(input logic [7:0] b, input logic [23:0] pos);
      scan_state = S_IDLE;
      if (b == 8'h00) finish_text(pos);
      else if (b == " " || b == 8'h0d || b == 8'h09) begin
      end else if (b == 8'h0a) next_line();
      else if (alpha_byte(b)) begin
         scan_state = S_IDENT;
         scan_begin = pos;
         scan_count = 1;
         scan_word[0] = b;
         scan_word_len = 1;
      end else if (digit_byte(b)) begin
         scan_state = S_NUM_INT;
         scan_begin = pos;
         scan_count = 1;
      end else if (b == "!" || b == "=" || b == "<" || b == ">") begin
         scan_state = S_OP;
         scan_held = b;
         scan_begin = pos;
      end else if (b == "/") begin
         scan_state = S_SLASH;
         scan_begin = pos;
      end else if (b == 8'h22 || b == 8'h27) begin
         scan_state = S_STR_BODY;
         scan_single = (b == 8'h27);
         scan_begin = pos;
         scan_count = 1;
      end else if (single_code(b) != 6'h3F) push_token(1'b0, single_code(b), FC_NONE, pos, 1, 8'h00);
      else push_token(1'b0, TK_ERROR, FC_CHAR, pos, 0, 8'h00);
   endfunction

   function automatic logic [5:0] compare_token(input logic [7:0] op, input bit two);
      logic [5:0] base;
      base = (op == "!") ? 6'd15 : (op == "=") ? 6'd17 : (op == ">") ? 6'd19 : 6'd21;
      return base + (two ? 6'd1 : 6'd0);
   endfunction

   // Advances the predictor by one byte and queues the records it causes.
   function automatic void lex_byte(input logic [7:0] b);
      logic [23:0] pos;
      logic [7:0]  quote;
      logic [7:0]  c;
      pos = scan_pos;
      scan_restart = 1'b0;
      run_tokens.delete();
      case (scan_state)
         S_IDENT: begin
            if (alpha_byte(b) || digit_byte(b)) begin
               if (scan_word_len < 8) scan_word[scan_word_len] = b;
               if (scan_word_len <= 8) scan_word_len++;
               add_count(1);
            end else begin
               push_token(1'b0, word_token(), FC_NONE, scan_begin, scan_count, 8'h00);
               scan_fresh(b, pos);
            end
         end
         S_NUM_INT, S_NUM_FRAC: begin
            if (digit_byte(b)) add_count(1);
            else if (b == "." && scan_state == S_NUM_INT) scan_state = S_NUM_DOT;
            else begin
               push_token(1'b0, TK_NUMBER, FC_NONE, scan_begin, scan_count, 8'h00);
               scan_fresh(b, pos);
            end
         end
         S_NUM_DOT: begin
            if (digit_byte(b)) begin
               add_count(2);
               scan_state = S_NUM_FRAC;
            end else begin
               push_token(1'b0, TK_NUMBER, FC_NONE, scan_begin, scan_count, 8'h00);
               push_token(1'b0, TK_DOT, FC_NONE, pos - 24'd1, 1, 8'h00);
               scan_fresh(b, pos);
            end
         end
         S_OP: begin
            if (b == "=") begin
               push_token(1'b0, compare_token(scan_held, 1), FC_NONE, scan_begin, 2, 8'h00);
               scan_state = S_IDLE;
            end else begin
               push_token(1'b0, compare_token(scan_held, 0), FC_NONE, scan_begin, 1, 8'h00);
               scan_fresh(b, pos);
            end
         end
         S_SLASH: begin
            if (b == "/") scan_state = S_LINE_CMT;
            else if (b == "*") scan_state = S_BLK_BODY;
            else begin
               push_token(1'b0, TK_SLASH, FC_NONE, scan_begin, 1, 8'h00);
               scan_fresh(b, pos);
            end
         end
         S_LINE_CMT: begin
            if (b == 8'h0a) begin
               next_line();
               scan_state = S_IDLE;
            end else if (b == 8'h00) scan_fresh(b, pos);
         end
         S_BLK_BODY, S_BLK_STAR: begin
            if (b == 8'h00) begin
               push_token(1'b0, TK_ERROR, FC_COMMENT, scan_begin, 0, 8'h00);
               finish_text(pos);
            end else if (b == "*") scan_state = S_BLK_STAR;
            else if (b == "/" && scan_state == S_BLK_STAR) scan_state = S_IDLE;
            else begin
               if (b == 8'h0a) next_line();
               scan_state = S_BLK_BODY;
            end
         end
         S_STR_BODY: begin
            quote = scan_single ? 8'h27 : 8'h22;
            if (b == quote) begin
               add_count(1);
               push_token(1'b0, TK_STRING, FC_NONE, scan_begin, scan_count, 8'h00);
               scan_state = S_IDLE;
            end else if (b == 8'h5c) scan_state = S_STR_ESC;
            else if (b == 8'h00) begin
               push_token(1'b0, TK_ERROR, FC_STRING, scan_begin, 0, 8'h00);
               finish_text(pos);
            end else begin
               add_count(1);
               push_token(1'b1, TK_STRING, FC_NONE, scan_begin, 0, b);
            end
         end
         S_STR_ESC: begin
            if (b == 8'h00) begin
               push_token(1'b0, TK_ERROR, FC_STRING, scan_begin, 0, 8'h00);
               finish_text(pos);
            end else if (b == 8'h27 || b == 8'h5c || b == 8'h22 || b == "n" || b == "r"
                  || b == "t") begin
               c = (b == "n") ? 8'h0a : (b == "r") ? 8'h0d : (b == "t") ? 8'h09 : b;
               add_count(1);
               push_token(1'b1, TK_STRING, FC_NONE, scan_begin, 0, c);
               scan_state = S_STR_BODY;
            end else begin
               push_token(1'b0, TK_ERROR, FC_ESCAPE, scan_begin, 0, 8'h00);
               scan_state = S_IDLE;
            end
         end
         default: scan_fresh(b, pos);
      endcase
      if (scan_restart) clear_scanner();
      else scan_pos = pos + 24'd1;
      if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
      foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
   endfunction

   // Predict on every accepted byte transfer.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) lex_byte(req.payload);
   end

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp.payload);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp.payload !== want) begin
               $display("%0t: result mismatch, expected %p, actual %p",
                  $time, want, rsp.payload);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, or ready held low throughout a hold-off stretch.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_off) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Sends one byte, with a random gap in front of it, and returns at the
   // edge where it is transferred.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= b;
      @(posedge clock iff req.ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_tokens.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Operators, punctuation, numbers, keywords, comments, strings and the repaired cases.
   task automatic test_directed();
      send_text("(){}[]:;,.-+/%* ! != = == > >= < <= 12.5 7. x\n");
      send_text("and break catch class continue else false for fun if nil or print");
      send_text(" return super this throw true try var while tx Abc_9zzzzzzzz ");
      send_text("/*/ x **/ // line\n'a\\'\\\\\\n\\r\\t\"' \"q\\x\" \x01\xff");
      send_byte(8'h00);
      send_text("/* open");
      send_byte(8'h00);
      send_text("\"open\n");
      send_byte(8'h00);
      send_text("'\\");
      send_byte(8'h00);
      drain();
   endtask

   // Random fragments with random content, plus raw noise.
   task automatic send_random_fragment();
      string fragments [12] = '{"ident", "kw", "num", "str", "op", "cmt", "blk",
         "punct", "ws", "noise", "nl", "end"};
      string pick;
      int    n;
      pick = fragments[$urandom_range(11)];
      case (pick)
         "ident": begin
            send_byte(8'("a" + $urandom_range(25)));
            n = $urandom_range(10);
            repeat (n) send_byte(8'($urandom_range(1) ? "0" + $urandom_range(9) : "_"));
         end
         "kw": send_text(keywords[$urandom_range(20)]);
         "num": begin
            send_byte(8'("0" + $urandom_range(9)));
            if ($urandom_range(1)) send_byte(".");
            repeat ($urandom_range(2)) send_byte(8'("0" + $urandom_range(9)));
         end
         "str": begin
            send_byte($urandom_range(1) ? 8'h22 : 8'h27);
            repeat ($urandom_range(5)) begin
               if ($urandom_range(4) == 0) send_byte(8'h5c);
               send_byte(8'($urandom_range(1, 255)));
            end
            send_byte($urandom_range(1) ? 8'h22 : 8'h27);
         end
         "op": begin
            send_byte($urandom_range(1) ? "<" : "!");
            send_byte($urandom_range(1) ? "=" : ">");
         end
         "cmt": send_text("// c\n");
         "blk": begin
            if ($urandom_range(1)) send_text("/* * \n */");
            else send_text("/*/**/");
         end
         "punct": send_byte($urandom_range(1) ? "(" : ";");
         "ws": send_byte($urandom_range(1) ? " " : 8'h09);
         "nl": send_byte(8'h0a);
         "end": if ($urandom_range(3) == 0) send_byte(8'h00);
         default: send_byte(8'($urandom_range(1, 255)));
      endcase
      send_byte(" ");
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_random_fragment();
      send_byte(8'h00);
      drain();
   endtask

   // Receiver holds off for a counted stretch while the sender keeps offering bytes.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      repeat (20) send_text("( ");
      send_byte(8'h00);
      drain();
   endtask

   initial begin
      req.valid = 1'b0;
      req.payload = 8'h00;
      clear_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 5);
      test_random_phase(51, 0, 5);
      test_random_phase(0, 51, 5);
      test_random_phase(9, 9, 5);
      test_backpressure();
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== script_lexer.f =====
+incdir+sv
sv/slex_pkg.sv
sv/slex_stream_if.sv
sv/slex_keyword.sv
sv/slex_out_queue.sv
sv/script_lexer.sv
tb/script_lexer_test.sv
